// ===== design/chinese_remainder_pair_top_defines.svh =====
// Assertion macros used by the top design file.
`ifndef CHINESE_REMAINDER_PAIR_TOP_DEFINES_SVH
`define CHINESE_REMAINDER_PAIR_TOP_DEFINES_SVH
// An implication checked on every clock edge outside reset.
`define CRP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// An implication whose consequence is checked at the next clock edge.
`define CRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== design/crp_pkg.sv =====
package crp_pkg;
  localparam int unsigned Width = 64;
  localparam int unsigned CntW = $clog2(Width + 1);

  typedef logic [Width-1:0] word_t;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StZeroMod = 2'd1;
  localparam logic [1:0] StNoSol = 2'd2;
  localparam logic [1:0] StOvf = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_RED1  = 18'h00002,
    S_RED2  = 18'h00004,
    S_DIFF  = 18'h00008,
    S_AMOD  = 18'h00010,
    S_GCD   = 18'h00020,
    S_GSTEP = 18'h00040,
    S_CHK   = 18'h00080,
    S_DIVA  = 18'h00100,
    S_DIVM  = 18'h00200,
    S_INV   = 18'h00400,
    S_INVQ  = 18'h00800,
    S_INVT  = 18'h01000,
    S_TMUL  = 18'h02000,
    S_LCM   = 18'h04000,
    S_LCHK  = 18'h08000,
    S_RES   = 18'h10000,
    S_DONE  = 18'h20000
  } state_t;
endpackage

// ===== design/chinese_remainder_pair_top.sv =====
// A zero modulus goes from idle straight to the done state, and a unit modulus goes there
// right after the two residue reductions.
// Every Euclid step waits for a restoring division, and every inverse step also for a
// shift-add modular multiply; these loops set the run time.
// A new pair is taken only in idle, once the last result is out; busy drops with the result strobe.
// Synchronous active-low reset returns the sequencer to idle; the receiver cannot stall.
`include "chinese_remainder_pair_top_defines.svh"
module chinese_remainder_pair_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [crp_pkg::Width-1:0]     in_first_residue,
  input  logic [crp_pkg::Width-1:0]     in_first_modulus,
  input  logic [crp_pkg::Width-1:0]     in_second_residue,
  input  logic [crp_pkg::Width-1:0]     in_second_modulus,
  output logic                          out_valid,
  output logic [crp_pkg::Width-1:0]     out_combined_residue,
  output logic [crp_pkg::Width-1:0]     out_combined_modulus,
  output logic [1:0]                    out_status
);
  crp_pkg::state_t state_r;
  crp_pkg::word_t r1_r, m1_r, r2_r, m2_r;
  crp_pkg::word_t d_r, a_r, g_r, ar_r, br_r, mr_r, t_r;
  crp_pkg::word_t x0_r, x1_r, t0_r, t1_r;
  crp_pkg::word_t res_r, lcm_r;
  logic [1:0]   status_r;
  logic         valid_r;

  // Shared divider: num / den, one quotient bit per cycle.
  crp_pkg::word_t dn_r, dd_r, dq_r, drem_r;
  logic [crp_pkg::CntW-1:0] cnt_r;
  logic         dbusy_r;
  // Shared shift-add multiplier, modular or plain with overflow tracking.
  crp_pkg::word_t acc_r, mx_r, my_r, mm_r;
  logic         mbusy_r;
  logic         plain_r;
  logic         xovf_r;
  logic         povf_r;

  crp_pkg::word_t rem_sh, acc_add, x_dbl, q_red;
  logic [crp_pkg::Width:0] trial, acc_sum, x_sum, acc_red, x_red;

  assign rem_sh = {drem_r[crp_pkg::Width-2:0], dn_r[crp_pkg::Width-1]};
  assign trial  = {drem_r[crp_pkg::Width-1], rem_sh} - {1'b0, dd_r};

  assign acc_sum = {1'b0, acc_r} + {1'b0, mx_r};
  assign acc_red = acc_sum - {1'b0, mm_r};
  assign acc_add = (plain_r || acc_red[crp_pkg::Width]) ? acc_sum[crp_pkg::Width-1:0]
                                                         : acc_red[crp_pkg::Width-1:0];
  assign x_sum   = {1'b0, mx_r} + {1'b0, mx_r};
  assign x_red   = x_sum - {1'b0, mm_r};
  assign x_dbl   = (plain_r || x_red[crp_pkg::Width]) ? x_sum[crp_pkg::Width-1:0]
                                                       : x_red[crp_pkg::Width-1:0];
  assign q_red   = (dq_r >= mr_r) ? dq_r - mr_r : dq_r;

  assign busy = (state_r != crp_pkg::S_IDLE);
  assign out_valid = valid_r;
  assign out_combined_residue = res_r;
  assign out_combined_modulus = lcm_r;
  assign out_status = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= (state_r == crp_pkg::S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crp_pkg::S_IDLE;
      dbusy_r <= 1'b0;
      mbusy_r <= 1'b0;
    end else if (dbusy_r) begin
      dn_r <= {dn_r[crp_pkg::Width-2:0], 1'b0};
      if (!trial[crp_pkg::Width]) begin
        drem_r <= trial[crp_pkg::Width-1:0];
        dq_r <= {dq_r[crp_pkg::Width-2:0], 1'b1};
      end else begin
        drem_r <= rem_sh;
        dq_r <= {dq_r[crp_pkg::Width-2:0], 1'b0};
      end
      cnt_r <= cnt_r - crp_pkg::CntW'(1);
      if (cnt_r == crp_pkg::CntW'(1)) dbusy_r <= 1'b0;
    end else if (mbusy_r) begin
      if (my_r[0]) begin
        acc_r <= acc_add;
        if (plain_r && (acc_sum[crp_pkg::Width] || xovf_r)) povf_r <= 1'b1;
      end
      mx_r <= x_dbl;
      if (plain_r && x_sum[crp_pkg::Width]) xovf_r <= 1'b1;
      my_r <= my_r >> 1;
      if (my_r[crp_pkg::Width-1:1] == '0) mbusy_r <= 1'b0;
    end else begin
      case (state_r)
        crp_pkg::S_IDLE: begin
          if (start) begin
            r1_r <= in_first_residue;
            m1_r <= in_first_modulus;
            r2_r <= in_second_residue;
            m2_r <= in_second_modulus;
            if (in_first_modulus == '0 || in_second_modulus == '0) begin
              status_r <= crp_pkg::StZeroMod;
              res_r <= '0;
              lcm_r <= '0;
              state_r <= crp_pkg::S_DONE;
            end else begin
              dn_r <= in_first_residue; dd_r <= in_first_modulus;
              drem_r <= '0; dq_r <= '0; cnt_r <= crp_pkg::CntW'(crp_pkg::Width);
              dbusy_r <= 1'b1;
              state_r <= crp_pkg::S_RED1;
            end
          end
        end
        crp_pkg::S_RED1: begin
          r1_r <= drem_r;
          dn_r <= r2_r; dd_r <= m2_r;
          drem_r <= '0; dq_r <= '0; cnt_r <= crp_pkg::CntW'(crp_pkg::Width); dbusy_r <= 1'b1;
          state_r <= crp_pkg::S_RED2;
        end
        crp_pkg::S_RED2: begin
          r2_r <= drem_r;
          status_r <= crp_pkg::StOk;
          if (m1_r == crp_pkg::word_t'(1)) begin
            res_r <= drem_r; lcm_r <= m2_r; state_r <= crp_pkg::S_DONE;
          end else if (m2_r == crp_pkg::word_t'(1)) begin
            res_r <= r1_r; lcm_r <= m1_r; state_r <= crp_pkg::S_DONE;
          end else begin
            dn_r <= r1_r; dd_r <= m2_r;
            drem_r <= '0; dq_r <= '0; cnt_r <= crp_pkg::CntW'(crp_pkg::Width);
            dbusy_r <= 1'b1;
            state_r <= crp_pkg::S_DIFF;
          end
        end
        crp_pkg::S_DIFF: begin
          d_r <= (r2_r >= drem_r) ? r2_r - drem_r : r2_r + (m2_r - drem_r);
          dn_r <= m1_r; dd_r <= m2_r;
          drem_r <= '0; dq_r <= '0; cnt_r <= crp_pkg::CntW'(crp_pkg::Width); dbusy_r <= 1'b1;
          state_r <= crp_pkg::S_AMOD;
        end
        crp_pkg::S_AMOD: begin
          a_r <= drem_r;
          x0_r <= drem_r;
          x1_r <= m2_r;
          state_r <= crp_pkg::S_GCD;
        end
        crp_pkg::S_GCD: begin
          if (x1_r == '0) begin
            g_r <= x0_r;
            dn_r <= d_r; dd_r <= x0_r;
            drem_r <= '0; dq_r <= '0; cnt_r <= crp_pkg::CntW'(crp_pkg::Width);
            dbusy_r <= 1'b1;
            state_r <= crp_pkg::S_CHK;
          end else begin
            dn_r <= x0_r; dd_r <= x1_r;
            drem_r <= '0; dq_r <= '0; cnt_r <= crp_pkg::CntW'(crp_pkg::Width);
            dbusy_r <= 1'b1;
            x0_r <= x1_r;
            state_r <= crp_pkg::S_GSTEP;
          end
        end
        crp_pkg::S_GSTEP: begin
          x1_r <= drem_r;
          state_r <= crp_pkg::S_GCD;
        end
        crp_pkg::S_CHK: begin
          if (drem_r != '0) begin
            status_r <= crp_pkg::StNoSol; res_r <= '0; lcm_r <= '0;
            state_r <= crp_pkg::S_DONE;
          end else begin
            br_r <= dq_r;
            dn_r <= a_r; dd_r <= g_r;
            drem_r <= '0; dq_r <= '0; cnt_r <= crp_pkg::CntW'(crp_pkg::Width);
            dbusy_r <= 1'b1;
            state_r <= crp_pkg::S_DIVA;
          end
        end
        crp_pkg::S_DIVA: begin
          ar_r <= dq_r;
          dn_r <= m2_r; dd_r <= g_r;
          drem_r <= '0; dq_r <= '0; cnt_r <= crp_pkg::CntW'(crp_pkg::Width); dbusy_r <= 1'b1;
          state_r <= crp_pkg::S_DIVM;
        end
        crp_pkg::S_DIVM: begin
          mr_r <= dq_r;
          x0_r <= dq_r; x1_r <= ar_r;
          t0_r <= '0; t1_r <= crp_pkg::word_t'(1);
          if (dq_r <= crp_pkg::word_t'(1)) begin
            t_r <= '0;
            dn_r <= m1_r; dd_r <= g_r;
            drem_r <= '0; dq_r <= '0; cnt_r <= crp_pkg::CntW'(crp_pkg::Width);
            dbusy_r <= 1'b1;
            state_r <= crp_pkg::S_LCM;
          end else begin
            state_r <= crp_pkg::S_INV;
          end
        end
        crp_pkg::S_INV: begin
          // Extended Euclid on (x0, x1) with the inverse in t0 once x1 reaches zero.
          if (x1_r == '0) begin
            mx_r <= t0_r; my_r <= br_r; mm_r <= mr_r; acc_r <= '0;
            plain_r <= 1'b0; mbusy_r <= 1'b1;
            state_r <= crp_pkg::S_TMUL;
          end else begin
            dn_r <= x0_r; dd_r <= x1_r;
            drem_r <= '0; dq_r <= '0; cnt_r <= crp_pkg::CntW'(crp_pkg::Width);
            dbusy_r <= 1'b1;
            state_r <= crp_pkg::S_INVQ;
          end
        end
        crp_pkg::S_INVQ: begin
          x0_r <= x1_r;
          x1_r <= drem_r;
          mx_r <= q_red; my_r <= t1_r; mm_r <= mr_r; acc_r <= '0;
          plain_r <= 1'b0; mbusy_r <= 1'b1;
          state_r <= crp_pkg::S_INVT;
        end
        crp_pkg::S_INVT: begin
          t0_r <= t1_r;
          t1_r <= (t0_r >= acc_r) ? t0_r - acc_r : t0_r + (mr_r - acc_r);
          state_r <= crp_pkg::S_INV;
        end
        crp_pkg::S_TMUL: begin
          t_r <= acc_r;
          dn_r <= m1_r; dd_r <= g_r;
          drem_r <= '0; dq_r <= '0; cnt_r <= crp_pkg::CntW'(crp_pkg::Width); dbusy_r <= 1'b1;
          state_r <= crp_pkg::S_LCM;
        end
        crp_pkg::S_LCM: begin
          mx_r <= dq_r; my_r <= m2_r; acc_r <= '0;
          plain_r <= 1'b1; xovf_r <= 1'b0; povf_r <= 1'b0; mbusy_r <= 1'b1;
          state_r <= crp_pkg::S_LCHK;
        end
        crp_pkg::S_LCHK: begin
          if (povf_r) begin
            status_r <= crp_pkg::StOvf; res_r <= '0; lcm_r <= '0;
            state_r <= crp_pkg::S_DONE;
          end else begin
            lcm_r <= acc_r;
            mx_r <= m1_r; my_r <= t_r; acc_r <= '0;
            plain_r <= 1'b1; xovf_r <= 1'b0; povf_r <= 1'b0; mbusy_r <= 1'b1;
            state_r <= crp_pkg::S_RES;
          end
        end
        crp_pkg::S_RES: begin
          res_r <= acc_r + r1_r;
          status_r <= crp_pkg::StOk;
          state_r <= crp_pkg::S_DONE;
        end
        crp_pkg::S_DONE: begin
          state_r <= crp_pkg::S_IDLE;
        end
        default: state_r <= crp_pkg::S_IDLE;
      endcase
    end
  end

  `CRP_ASSERT_IMP(a_busy_no_valid, busy, !out_valid)
  `CRP_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `CRP_ASSERT_IMP(a_ok_nonzero_mod, out_valid && out_status == crp_pkg::StOk,
                  out_combined_modulus != '0)
  `CRP_ASSERT_IMP(a_units_exclusive, dbusy_r, !mbusy_r)
endmodule
